/* sv/irs_pkg.sv */
// Shared types and constants for the image resampler.
// Depends on nothing; irs_catmull, the top level and the testbench refer to it by scoped names.
`default_nettype none

package irs_pkg;

    // Fixed-point layout
    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 8;
    // Signed width of a Catmull-Rom tap or pass result
    localparam int VAL_BITS   = 20;
    // Signed width of the Horner accumulator
    localparam int ACC_BITS   = 34;
    // Signed width of a source position (origin + coord * step)
    localparam int POS_BITS   = 39;
    // Signed width of a neighbour coordinate before clamping
    localparam int COORD_BITS = 25;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_ORG_X  = 3'd4;
    localparam logic [2:0] CFG_ORG_Y  = 3'd5;

    // Sample modes (codes 2 and 3 both mean bicubic)
    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_BILINEAR = 2'd1;

    // Item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [15:0] sample;
        logic        saturated;
    } t_out_word;

endpackage

`default_nettype wire

/* sv/irs_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module irs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write or read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/irs_catmull.sv */
// Shared 1-D Catmull-Rom unit: Horner evaluation with one multiplier,
// three multiply/add steps. Depends on irs_pkg.
`default_nettype none

module irs_catmull (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [irs_pkg::VAL_BITS-1:0]    i_p [4],
    input  wire logic        [irs_pkg::FRAC_BITS-1:0]   i_t,
    output logic                                        o_done,
    output logic signed      [irs_pkg::VAL_BITS-1:0]    o_result
);

    localparam int AB = irs_pkg::ACC_BITS;
    localparam int FB = irs_pkg::FRAC_BITS;
    localparam int GB = irs_pkg::GUARD_BITS;
    localparam logic signed [AB-1:0] GS_HALF = AB'(1) <<< GB;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_FIN} t_state;

    t_state                  r_state;
    logic signed [AB-1:0]    r_a, r_b, r_c, r_r;
    logic signed [AB+FB:0]   r_prod;
    logic        [FB-1:0]    r_t;
    logic        [1:0]       r_step;
    logic                    r_done;
    logic signed [irs_pkg::VAL_BITS-1:0] r_result;

    logic signed [AB-1:0] e0, e1, e2, e3;
    logic signed [AB-1:0] n_c, n_d, coef, n_r, n_fin;

    // Polynomial coefficients from the four taps
    assign e0  = AB'(i_p[0]);
    assign e1  = AB'(i_p[1]);
    assign e2  = AB'(i_p[2]);
    assign e3  = AB'(i_p[3]);
    assign n_c = (e0 <<< 1) - (e1 * AB'(5)) + (e2 <<< 2) - e3;
    assign n_d = (e1 * AB'(3)) - (e2 * AB'(3)) + e3 - e0;

    // Coefficient added after each multiply: c, then b, then a
    always_comb begin
        case (r_step)
            2'd0:    coef = r_c;
            2'd1:    coef = r_b;
            default: coef = r_a;
        endcase
    end

    assign n_r   = AB'(r_prod >>> FB) + (coef <<< GB);
    assign n_fin = (r_r + GS_HALF) >>> (GB + 1);

    // Sequencer, datapath registers and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= e1 <<< 1;
                        r_b     <= e2 - e0;
                        r_c     <= n_c;
                        r_r     <= n_d <<< GB;
                        r_t     <= i_t;
                        r_step  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_r * $signed({1'b0, r_t});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_r    <= n_r;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    r_result <= n_fin[irs_pkg::VAL_BITS-1:0];
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* sv/image_resampler_top.sv */
// Image resampler top level: configuration, position math, fetch sequencer
// and output register. Depends on irs_pkg, irs_ram and irs_catmull.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+---------------------------
//  in      | into      | i_in_valid / o_in_stall | i_in_word  (t_in_word)
//  out     | out of    | o_out_valid/i_out_stall | o_out_word (t_out_word)
//  cfg     | into      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A bicubic read word makes sixteen reads of the single-port image RAM and
// five passes through the shared Catmull-Rom unit. Reset is synchronous,
// active low, and clears control state and configuration; the image RAM is
// not cleared. A finished result waits in the output register while the
// next word is taken.
`default_nettype none

module image_resampler_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire irs_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output irs_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int PB = irs_pkg::PIXEL_BITS;
    localparam int FB = irs_pkg::FRAC_BITS;
    localparam int VB = irs_pkg::VAL_BITS;
    localparam int PS = irs_pkg::POS_BITS;
    localparam int CW = irs_pkg::COORD_BITS;
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam logic [FB:0]            ONE     = (FB+1)'(1) << FB;
    localparam logic [PS-1:0]          HALF    = PS'(1) << (FB - 1);
    localparam logic [PB+2*FB+1:0]     RND     = (PB+2*FB+2)'(1) << (2*FB - 1);
    localparam logic signed [VB-1:0]   PIX_MAX = VB'((1 << PB) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MPOS, S_APOS, S_FETCH, S_ROW, S_COL, S_FIN, S_OUT
    } t_state;

    // Configuration registers
    logic [1:0]  r_cfg_mode;
    logic [7:0]  r_cfg_w, r_cfg_h;
    logic [23:0] r_cfg_step;
    logic [31:0] r_cfg_ox, r_cfg_oy;

    // Sequencer and datapath registers
    t_state                 r_state;
    logic [11:0]            r_col, r_row;
    logic [35:0]            r_mx, r_my;
    logic [PS-1:0]          r_px, r_py;
    logic [3:0]             r_cnt;
    logic                   r_issue, r_v1, r_v2;
    logic [2*FB:0]          r_w;
    logic [PB+2*FB:0]       r_prod;
    logic [PB+2*FB+1:0]     r_acc;
    logic [PB-1:0]          r_taps [16];
    logic signed [VB-1:0]   r_rowv [4];
    logic [1:0]             r_pass;
    logic                   r_cm_start;
    logic [PB-1:0]          r_result;
    logic                   r_sat;
    logic                   r_ovalid;
    irs_pkg::t_out_word     r_oword;

    // Combinational signals
    logic                   in_acc, n_we, n_in_range, n_last;
    logic                   n_cm_start, n_load, n_ovalid;
    logic [AW-1:0]          n_addr, n_waddr, n_raddr;
    logic [PB-1:0]          ram_q;
    logic [12:0]            w_eff, h_eff;
    logic [XW-1:0]          wm1, cx;
    logic [YW-1:0]          hm1, cy;
    logic signed [CW-1:0]   xs, ys, ix, iy;
    logic [PS-1:0]          npx, npy;
    logic [FB-1:0]          tx, ty;
    logic [FB:0]            wx, wy;
    logic [2*FB+1:0]        n_wfull;
    logic [PB+2*FB+1:0]     n_bl;
    logic signed [VB-1:0]   cm_p [4];
    logic [FB-1:0]          cm_t;
    logic                   cm_done;
    logic signed [VB-1:0]   cm_res;

    // Configuration port: always ready; it must be written while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= irs_pkg::MODE_BILINEAR;
            r_cfg_w    <= 8'd128;
            r_cfg_h    <= 8'd128;
            r_cfg_step <= 24'(1) << FB;
            r_cfg_ox   <= '0;
            r_cfg_oy   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                irs_pkg::CFG_MODE:   r_cfg_mode <= i_cfg_data[1:0];
                irs_pkg::CFG_WIDTH:  r_cfg_w    <= i_cfg_data[7:0];
                irs_pkg::CFG_HEIGHT: r_cfg_h    <= i_cfg_data[7:0];
                irs_pkg::CFG_STEP:   r_cfg_step <= i_cfg_data[23:0];
                irs_pkg::CFG_ORG_X:  r_cfg_ox   <= i_cfg_data;
                irs_pkg::CFG_ORG_Y:  r_cfg_oy   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective image size: zero acts as one, oversize as the maximum
    always_comb begin
        if (r_cfg_w == 8'd0) begin
            w_eff = 13'd1;
        end else if ({5'd0, r_cfg_w} > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = {5'd0, r_cfg_w};
        end
        if (r_cfg_h == 8'd0) begin
            h_eff = 13'd1;
        end else if ({5'd0, r_cfg_h} > 13'(MAX_HEIGHT)) begin
            h_eff = 13'(MAX_HEIGHT);
        end else begin
            h_eff = {5'd0, r_cfg_h};
        end
    end

    assign wm1 = XW'(w_eff - 13'd1);
    assign hm1 = YW'(h_eff - 13'd1);

    // Integer and fraction parts of the source position
    assign npx = r_px + HALF;
    assign npy = r_py + HALF;
    assign ix  = CW'($signed(r_px[PS-1:FB]));
    assign iy  = CW'($signed(r_py[PS-1:FB]));
    assign tx  = r_px[FB-1:0];
    assign ty  = r_py[FB-1:0];

    // Neighbour coordinate of the tap being issued, then edge clamp
    always_comb begin
        case (r_cfg_mode)
            irs_pkg::MODE_NEAREST: begin
                xs     = CW'($signed(npx[PS-1:FB]));
                ys     = CW'($signed(npy[PS-1:FB]));
                n_last = 1'b1;
            end
            irs_pkg::MODE_BILINEAR: begin
                xs     = ix + CW'(r_cnt[0]);
                ys     = iy + CW'(r_cnt[1]);
                n_last = (r_cnt == 4'd3);
            end
            default: begin
                xs     = ix + CW'(r_cnt[1:0]) - CW'(1);
                ys     = iy + CW'(r_cnt[3:2]) - CW'(1);
                n_last = (r_cnt == 4'd15);
            end
        endcase
        if (xs[CW-1]) begin
            cx = '0;
        end else if (xs > CW'(wm1)) begin
            cx = wm1;
        end else begin
            cx = xs[XW-1:0];
        end
        if (ys[CW-1]) begin
            cy = '0;
        end else if (ys > CW'(hm1)) begin
            cy = hm1;
        end else begin
            cy = ys[YW-1:0];
        end
    end

    // Bilinear weight of the tap being issued
    assign wx      = r_cnt[0] ? {1'b0, tx} : ONE - {1'b0, tx};
    assign wy      = r_cnt[1] ? {1'b0, ty} : ONE - {1'b0, ty};
    assign n_wfull = (2*FB+2)'(wx) * (2*FB+2)'(wy);
    assign n_bl    = r_acc + RND;

    // RAM port: input writes while idle, neighbour reads while fetching
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign n_in_range = ({1'b0, i_in_word.col} < 13'(MAX_WIDTH)) &&
                        ({1'b0, i_in_word.row} < 13'(MAX_HEIGHT));
    assign n_we       = in_acc && (i_in_word.op == irs_pkg::OP_WRITE) && n_in_range;
    assign n_waddr    = AW'(AW'(i_in_word.row) * AW'(MAX_WIDTH)) + AW'(i_in_word.col);
    assign n_raddr    = AW'(AW'(cy) * AW'(MAX_WIDTH)) + AW'(cx);
    assign n_addr     = (r_state == S_IDLE) ? n_waddr : n_raddr;

    irs_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (i_in_word.pixel_in),
        .o_rdata (ram_q)
    );

    // Catmull-Rom operands: row passes take four taps, the column pass
    // takes the four row results
    always_comb begin
        if (r_state == S_COL) begin
            for (int k = 0; k < 4; k++) begin
                cm_p[k] = r_rowv[k];
            end
            cm_t = ty;
        end else begin
            for (int k = 0; k < 4; k++) begin
                cm_p[k] = VB'($signed({1'b0, r_taps[k]}));
            end
            cm_t = tx;
        end
    end

    irs_catmull u_cm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_cm_start),
        .i_p      (cm_p),
        .i_t      (cm_t),
        .o_done   (cm_done),
        .o_result (cm_res)
    );

    // Pass start: after the bicubic fetch drains, and after each row pass
    assign n_cm_start = ((r_state == S_FETCH) && !r_issue && !r_v1 && !r_v2 &&
                         (r_cfg_mode != irs_pkg::MODE_NEAREST) &&
                         (r_cfg_mode != irs_pkg::MODE_BILINEAR)) ||
                        ((r_state == S_ROW) && cm_done);

    // Output register load and hold
    assign n_load   = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);
    assign n_ovalid = n_load || (r_ovalid && i_out_stall);

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_cm_start <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_cm_start <= n_cm_start;
            r_ovalid   <= n_ovalid;
            r_v1       <= (r_state == S_FETCH) && r_issue;
            r_v2       <= r_v1;
            // fetch pipeline: weight with the read, product, accumulate
            if (r_v1) begin
                for (int k = 0; k < 15; k++) begin
                    r_taps[k] <= r_taps[k+1];
                end
                r_taps[15] <= ram_q;
                r_prod     <= ram_q * r_w;
            end
            if (r_v2) begin
                r_acc <= r_acc + (PB+2*FB+2)'(r_prod);
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_word.op == irs_pkg::OP_READ)) begin
                        r_col   <= i_in_word.col;
                        r_row   <= i_in_word.row;
                        r_state <= S_MPOS;
                    end
                end
                S_MPOS: begin
                    r_mx    <= 36'(r_col) * 36'(r_cfg_step);
                    r_my    <= 36'(r_row) * 36'(r_cfg_step);
                    r_state <= S_APOS;
                end
                S_APOS: begin
                    r_px    <= PS'($signed(r_cfg_ox)) + PS'(r_mx);
                    r_py    <= PS'($signed(r_cfg_oy)) + PS'(r_my);
                    r_cnt   <= '0;
                    r_issue <= 1'b1;
                    r_acc   <= '0;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    if (r_issue) begin
                        r_w <= n_wfull[2*FB:0];
                        if (n_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end else if (!r_v1 && !r_v2) begin
                        if ((r_cfg_mode == irs_pkg::MODE_NEAREST) ||
                            (r_cfg_mode == irs_pkg::MODE_BILINEAR)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_pass  <= 2'd0;
                            r_state <= S_ROW;
                        end
                    end
                end
                S_ROW: begin
                    if (cm_done) begin
                        for (int k = 0; k < 3; k++) begin
                            r_rowv[k] <= r_rowv[k+1];
                        end
                        r_rowv[3] <= cm_res;
                        for (int k = 0; k < 12; k++) begin
                            r_taps[k] <= r_taps[k+4];
                        end
                        r_pass <= r_pass + 2'd1;
                        if (r_pass == 2'd3) begin
                            r_state <= S_COL;
                        end
                    end
                end
                S_COL: begin
                    if (cm_done) begin
                        if (cm_res[VB-1]) begin
                            r_result <= '0;
                            r_sat    <= 1'b1;
                        end else if (cm_res > PIX_MAX) begin
                            r_result <= PIX_MAX[PB-1:0];
                            r_sat    <= 1'b1;
                        end else begin
                            r_result <= cm_res[PB-1:0];
                            r_sat    <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_FIN: begin
                    if (r_cfg_mode == irs_pkg::MODE_NEAREST) begin
                        r_result <= r_taps[15];
                    end else begin
                        r_result <= n_bl[2*FB +: PB];
                    end
                    r_sat   <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (n_load) begin
                        r_oword.sample    <= r_result;
                        r_oword.saturated <= r_sat;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for image_resampler_top: loads small source images,
// reads resampled pixels in every mode and checks them against a predictor.
// Depends on irs_pkg and the image_resampler_top RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int IMG_MAX = 128;
    localparam logic [1:0] MODE_BICUBIC = 2'd2;
    localparam int SETTLE_CYCLES = 80;

    // Scoreboard: predicts resampled pixels from its own image copy and config
    class resample_scoreboard;
        logic [15:0] pix_copy [IMG_MAX*IMG_MAX];
        logic [1:0]  mode;
        logic [7:0]  width_reg;
        logic [7:0]  height_reg;
        logic [23:0] step;
        longint      org_x;
        longint      org_y;
        irs_pkg::t_out_word pending_q[$];
        int          errors;
        int          reads;
        int          checked;

        function new();
            mode = irs_pkg::MODE_BILINEAR;
            width_reg = 8'd128;
            height_reg = 8'd128;
            step = 24'h010000;
            org_x = 0;
            org_y = 0;
            errors = 0;
            reads = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                irs_pkg::CFG_MODE:   mode = data[1:0];
                irs_pkg::CFG_WIDTH:  width_reg = data[7:0];
                irs_pkg::CFG_HEIGHT: height_reg = data[7:0];
                irs_pkg::CFG_STEP:   step = data[23:0];
                irs_pkg::CFG_ORG_X:  org_x = longint'($signed(data));
                irs_pkg::CFG_ORG_Y:  org_y = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > IMG_MAX) return IMG_MAX;
            return width_reg;
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > IMG_MAX) return IMG_MAX;
            return height_reg;
        endfunction

        // Edge-clamped neighbor fetch
        function longint pixel_at(longint x, longint y);
            longint cx;
            longint cy;
            cx = (x < 0) ? 0 : ((x > eff_width() - 1) ? eff_width() - 1 : x);
            cy = (y < 0) ? 0 : ((y > eff_height() - 1) ? eff_height() - 1 : y);
            return longint'(pix_copy[cy*IMG_MAX + cx]);
        endfunction

        // One Catmull-Rom pass, Horner form with 8 guard bits
        function longint cubic_pass(longint p0, longint p1, longint p2, longint p3,
                                    longint t);
            longint a;
            longint b;
            longint c;
            longint d;
            longint acc;
            a = 2*p1;
            b = p2 - p0;
            c = 2*p0 - 5*p1 + 4*p2 - p3;
            d = -p0 + 3*p1 - 3*p2 + p3;
            acc = d * 256;
            acc = ((acc * t) >>> irs_pkg::FRAC_BITS) + c * 256;
            acc = ((acc * t) >>> irs_pkg::FRAC_BITS) + b * 256;
            acc = ((acc * t) >>> irs_pkg::FRAC_BITS) + a * 256;
            return (acc + 256) >>> (irs_pkg::GUARD_BITS + 1);
        endfunction

        function void note_input(irs_pkg::t_in_word w);
            longint px;
            longint py;
            longint ix;
            longint iy;
            longint tx;
            longint ty;
            longint one;
            longint h1;
            longint h2;
            longint v;
            longint rowv [4];
            irs_pkg::t_out_word res;
            one = 65536;
            if (w.op == irs_pkg::OP_WRITE) begin
                if (w.col < IMG_MAX && w.row < IMG_MAX)
                    pix_copy[w.row*IMG_MAX + w.col] = w.pixel_in;
                return;
            end
            reads++;
            px = org_x + longint'(w.col) * longint'(step);
            py = org_y + longint'(w.row) * longint'(step);
            ix = px >>> irs_pkg::FRAC_BITS;
            iy = py >>> irs_pkg::FRAC_BITS;
            tx = longint'(px[15:0]);
            ty = longint'(py[15:0]);
            res.saturated = 1'b0;
            if (mode == irs_pkg::MODE_NEAREST) begin
                v = pixel_at((px + 32768) >>> irs_pkg::FRAC_BITS,
                             (py + 32768) >>> irs_pkg::FRAC_BITS);
            end else if (mode == irs_pkg::MODE_BILINEAR) begin
                h1 = pixel_at(ix, iy) * (one - tx) + pixel_at(ix + 1, iy) * tx;
                h2 = pixel_at(ix, iy + 1) * (one - tx) + pixel_at(ix + 1, iy + 1) * tx;
                v = (h1 * (one - ty) + h2 * ty + (longint'(1) << 31)) >>> 32;
            end else begin
                for (int k = 0; k < 4; k++)
                    rowv[k] = cubic_pass(pixel_at(ix - 1, iy - 1 + k),
                                         pixel_at(ix, iy - 1 + k),
                                         pixel_at(ix + 1, iy - 1 + k),
                                         pixel_at(ix + 2, iy - 1 + k), tx);
                v = cubic_pass(rowv[0], rowv[1], rowv[2], rowv[3], ty);
                if (v < 0) begin
                    v = 0;
                    res.saturated = 1'b1;
                end else if (v > 65535) begin
                    v = 65535;
                    res.saturated = 1'b1;
                end
            end
            res.sample = v[15:0];
            pending_q.push_back(res);
        endfunction

        function void check_result(irs_pkg::t_out_word got);
            irs_pkg::t_out_word exp_w;
            if (pending_q.size() == 0) begin
                $error("result word with no read outstanding: %h", got);
                errors++;
                return;
            end
            exp_w = pending_q.pop_front();
            checked++;
            if (got.sample !== exp_w.sample) begin
                $error("sample: expected %h, got %h", exp_w.sample, got.sample);
                errors++;
            end
            if (got.saturated !== exp_w.saturated) begin
                $error("saturated: expected %b, got %b", exp_w.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    irs_pkg::t_in_word  i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    irs_pkg::t_out_word o_out_word;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    resample_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int phases = 0;

    image_resampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check accepted words, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_word);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one input word; random idle cycles come before it
    task automatic send_word(logic op, logic [11:0] col, logic [11:0] row,
                             logic [15:0] pix);
        irs_pkg::t_in_word w;
        w.op = op;
        w.col = col;
        w.row = row;
        w.pixel_in = pix;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
        words_sent++;
    endtask

    // Drop valid and wait until every read has answered and the block is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers, block idle
    task automatic configure(logic [1:0] mode, logic [7:0] w, logic [7:0] h,
                             logic [23:0] step, logic [31:0] ox, logic [31:0] oy);
        logic [31:0] vals [6];
        vals = '{32'(mode), 32'(w), 32'(h), 32'(step), ox, oy};
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(3'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load every pixel of the active region so no read hits an unwritten entry
    task automatic fill_region();
        for (int r = 0; r < sb.eff_height(); r++)
            for (int c = 0; c < sb.eff_width(); c++)
                send_word(irs_pkg::OP_WRITE, 12'(c), 12'(r), 16'($urandom));
    endtask

    task automatic random_phase(int n);
        logic [7:0]  w;
        logic [7:0]  h;
        logic [23:0] step;
        logic [31:0] org [2];
        int          kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            w = ($urandom_range(1)) ? 8'd128 : 8'd255;
            h = 8'($urandom_range(2));
        end else if (kind == 1) begin
            h = ($urandom_range(1)) ? 8'd128 : 8'd255;
            w = 8'($urandom_range(2));
        end else begin
            w = 8'($urandom_range(8));
            h = 8'($urandom_range(8));
        end
        case ($urandom_range(9))
            0: step = 24'd0;
            1: step = 24'd1;
            2: step = 24'hFFFFFF;
            3: step = 24'($urandom);
            default: step = 24'($urandom_range(32'h1000, 32'h30000));
        endcase
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(9))
                0: org[i] = 32'h8000_0000;
                1: org[i] = 32'h7FFF_FFFF;
                2: org[i] = $urandom;
                default: org[i] = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            endcase
        end
        configure(2'($urandom_range(3)), w, h, step, org[0], org[1]);
        fill_region();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(99) < 70)
                    send_word(irs_pkg::OP_READ, 12'($urandom_range(15)),
                              12'($urandom_range(15)), 16'($urandom));
                else
                    send_word(irs_pkg::OP_READ, 12'($urandom), 12'($urandom),
                              16'($urandom));
            end else if ($urandom_range(99) < 80) begin
                send_word(irs_pkg::OP_WRITE, 12'($urandom_range(sb.eff_width() - 1)),
                          12'($urandom_range(sb.eff_height() - 1)), 16'($urandom));
            end else begin
                send_word(irs_pkg::OP_WRITE, 12'($urandom), 12'($urandom), 16'($urandom));
            end
        end
        drain();
    endtask

    // Main sequence
    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: checkerboard of extremes, bicubic at half step for overshoot
        configure(MODE_BICUBIC, 8'd4, 8'd4, 24'h008000, 32'd0, 32'd0);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_word(irs_pkg::OP_WRITE, 12'(c), 12'(r),
                          ((r + c) % 2) ? 16'hFFFF : 16'h0000);
        send_word(irs_pkg::OP_WRITE, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_word(irs_pkg::OP_WRITE, 12'd128, 12'd0, 16'h1234);
        send_word(irs_pkg::OP_READ, 12'd0, 12'd0, 16'h0000);
        send_word(irs_pkg::OP_READ, 12'd1, 12'd1, 16'hFFFF);
        send_word(irs_pkg::OP_READ, 12'd3, 12'd2, 16'h0000);
        send_word(irs_pkg::OP_READ, 12'd1, 12'd0, 16'h0000);
        send_word(irs_pkg::OP_READ, 12'hFFF, 12'hFFF, 16'h0000);
        drain();

        // Random phases, rotating through the idle and stall mixes
        while (words_sent < 1900) begin
            case (phases % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            random_phase(150);
            phases++;
        end

        $display("Covered %0d input words (%0d reads, %0d results checked) over %0d phases",
                 words_sent, sb.reads, sb.checked, phases);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
sv/irs_pkg.sv
sv/irs_ram.sv
sv/irs_catmull.sv
sv/image_resampler_top.sv
tb/sv/tb_top.sv
